### src/bswer_pkg.sv
// ----------------------------------------------------------------------------
// bswer_pkg
// Shared widths, the slot width reset value and divider handshake types for the sliding
// window event rate block.
// ----------------------------------------------------------------------------
package bswer_pkg;

   localparam int SLOT_COUNT_DEF = 16;
   localparam int COUNT_W        = 8;
   localparam int TIME_W         = 32;
   localparam int TOTAL_W        = 32;
   localparam int WIDTH_W        = 16;
   // window length in ms: 16-bit slot width times up to 256 slots
   localparam int DIV_W          = 24;
   localparam int STEP_W         = 6;

   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 16'd62;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  rem_init;
      logic [TIME_W-1:0] dividend;
      logic [STEP_W-1:0] steps;
      logic [DIV_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [TIME_W-1:0] quotient;
      logic [DIV_W-1:0]  remainder;
   } div_rsp_type;

endpackage

### src/bswer_ram.sv
// ----------------------------------------------------------------------------
// bswer_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bswer_ram #(
   parameter  int WIDTH = 32,
   parameter  int DEPTH = 16,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/bswer_div.sv
// ----------------------------------------------------------------------------
// bswer_div
// Serial restoring divider, one quotient bit per cycle. The remainder can be
// preloaded so a short run finishes a division whose quotient is known narrow.
// ----------------------------------------------------------------------------
module bswer_div (
   input  logic                   clock,
   input  logic                   reset,
   input  bswer_pkg::div_req_type div_req,
   output bswer_pkg::div_rsp_type div_rsp
);

   localparam int DW = bswer_pkg::DIV_W;
   localparam int TW = bswer_pkg::TIME_W;
   localparam int SW = bswer_pkg::STEP_W;

   logic          run_ff,  run_in;
   logic          done_ff, done_in;
   logic [SW-1:0] cnt_ff,  cnt_in;
   logic [DW-1:0] rem_ff,  rem_in;
   logic [TW-1:0] dvd_ff,  dvd_in;
   logic [TW-1:0] quo_ff,  quo_in;
   logic [DW-1:0] dsr_ff,  dsr_in;

   logic [DW:0]   trial;
   logic [DW:0]   diff;

   always_comb begin
      trial   = {rem_ff, dvd_ff[TW-1]};
      diff    = trial - {1'b0, dsr_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         run_in = 1'b1;
         cnt_in = div_req.steps;
         rem_in = div_req.rem_init;
         dvd_in = div_req.dividend;
         quo_in = '0;
         dsr_in = div_req.divisor;
      end else if (run_ff) begin
         // remainder stays below the divisor, so trial < 2 * divisor
         rem_in = diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
         quo_in = {quo_ff[TW-2:0], ~diff[DW]};
         dvd_in = {dvd_ff[TW-2:0], 1'b0};
         cnt_in = cnt_ff - SW'(1);
         if (cnt_ff == SW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

### src/bucketed_sliding_window_event_rate.sv
// ----------------------------------------------------------------------------
// bucketed_sliding_window_event_rate
// Ring of per-slot event counters spanning one window, with a running total.
//
//   channel  direction  handshake        payload
//   req      in         valid / stall    req_event_count[7:0], req_time_ms[31:0]
//   rsp      out        valid / stall    rsp_window_total[31:0]
//   csr      in         valid / ready    csr_slot_width_ms[15:0]
//
// One word at a time: the next req word is accepted only after the previous
// one has finished. The serial divider first finds the window number, then
// the slot within it. Each skipped slot is read from the RAM and taken off
// the total in the walk, followed by a drain state when any are skipped.
// Reset clears all slot valid bits at once; no sweep of the RAM is needed.
// A stalled rsp word holds; the next req word is taken while it waits.
// ----------------------------------------------------------------------------
module bucketed_sliding_window_event_rate #(
   parameter int SLOT_COUNT = bswer_pkg::SLOT_COUNT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bswer_pkg::COUNT_W-1:0]     req_event_count,
   input  logic [bswer_pkg::TIME_W-1:0]      req_time_ms,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bswer_pkg::TOTAL_W-1:0]     rsp_window_total,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bswer_pkg::WIDTH_W-1:0]     csr_slot_width_ms
);

   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam int DW    = bswer_pkg::DIV_W;
   localparam int TW    = bswer_pkg::TIME_W;
   localparam int OW    = bswer_pkg::TOTAL_W;
   localparam int CW    = bswer_pkg::COUNT_W;
   localparam int WW    = bswer_pkg::WIDTH_W;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DIV1  = 3'd1;
   localparam logic [2:0] S_DIV2  = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_WRITE = 3'd4;
   localparam logic [2:0] S_WALK  = 3'd5;
   localparam logic [2:0] S_DRAIN = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   localparam logic [1:0] MODE_CLEAR = 2'd0;
   localparam logic [1:0] MODE_SAME  = 2'd1;
   localparam logic [1:0] MODE_OTHER = 2'd2;

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] slot);
      next_slot = (slot == LAST_IDX) ? '0 : slot + IDX_W'(1);
   endfunction

   logic [2:0]            state_ff,     state_in;
   logic [SLOT_COUNT-1:0] valid_ff,     valid_in;
   logic [OW-1:0]         total_ff,     total_in;
   logic [TW-1:0]         last_win_ff,  last_win_in;
   logic [IDX_W-1:0]      last_idx_ff,  last_idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OW-1:0]         rsp_total_ff, rsp_total_in;
   logic [WW-1:0]         width_ff,     width_in;
   logic [DW-1:0]         win_ms_ff,    win_ms_in;
   logic                  sub_pend_ff,  sub_pend_in;
   logic [CW-1:0]         count_ff,     count_in;
   logic [TW-1:0]         win_ff,       win_in;
   logic [IDX_W-1:0]      idx_ff,       idx_in;
   logic [1:0]            mode_ff,      mode_in;
   logic                  cap_valid_ff, cap_valid_in;
   logic [IDX_W-1:0]      ptr_ff,       ptr_in;

   bswer_pkg::div_req_type div_req;
   bswer_pkg::div_rsp_type div_rsp;

   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   logic [OW-1:0]    ram_wr_data;
   logic             ram_rd_en;
   logic [IDX_W-1:0] ram_rd_addr;
   logic [OW-1:0]    ram_rd_data;

   logic [WW-1:0]    width_eff;
   logic [TW-1:0]    win_diff;
   logic [OW-1:0]    old_count;
   logic [OW-1:0]    count_ext;

   bswer_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   bswer_ram #(
      .WIDTH (OW),
      .DEPTH (SLOT_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_stall        = (state_ff != S_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_window_total = rsp_total_ff;

   assign width_eff = (csr_slot_width_ms == '0) ? WW'(1) : csr_slot_width_ms;
   assign win_diff  = win_ff - last_win_ff;
   assign old_count = cap_valid_ff ? ram_rd_data : '0;
   assign count_ext = OW'(count_ff);

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      total_in     = total_ff;
      last_win_in  = last_win_ff;
      last_idx_in  = last_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_total_in = rsp_total_ff;
      width_in     = width_ff;
      win_ms_in    = win_ms_ff;
      sub_pend_in  = 1'b0;
      count_in     = count_ff;
      win_in       = win_ff;
      idx_in       = idx_ff;
      mode_in      = mode_ff;
      cap_valid_in = cap_valid_ff;
      ptr_in       = ptr_ff;

      div_req.start    = 1'b0;
      div_req.rem_init = '0;
      div_req.dividend = req_time_ms;
      div_req.steps    = bswer_pkg::STEP_W'(TW);
      div_req.divisor  = win_ms_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff;
      ram_wr_data = count_ext;
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx_ff;

      if (csr_valid) begin
         width_in  = width_eff;
         win_ms_in = DW'(width_eff) * DW'(SLOT_COUNT);
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               count_in      = req_event_count;
               div_req.start = 1'b1;
               state_in      = S_DIV1;
            end
         end
         S_DIV1: begin
            // window number done; remainder / slot width gives the slot
            div_req.rem_init = div_rsp.remainder >> IDX_W;
            div_req.dividend = {div_rsp.remainder[IDX_W-1:0], {(TW-IDX_W){1'b0}}};
            div_req.steps    = bswer_pkg::STEP_W'(IDX_W);
            div_req.divisor  = DW'(width_ff);
            if (div_rsp.done) begin
               win_in        = div_rsp.quotient;
               div_req.start = 1'b1;
               state_in      = S_DIV2;
            end
         end
         S_DIV2: begin
            if (div_rsp.done) begin
               idx_in   = div_rsp.quotient[IDX_W-1:0];
               state_in = S_READ;
            end
         end
         S_READ: begin
            ram_rd_en    = 1'b1;
            cap_valid_in = valid_ff[idx_ff];
            if ((win_diff > TW'(1)) ||
                ((win_ff > last_win_ff) && (idx_ff >= last_idx_ff))) begin
               mode_in = MODE_CLEAR;
            end else if (idx_ff == last_idx_ff) begin
               mode_in = MODE_SAME;
            end else begin
               mode_in = MODE_OTHER;
            end
            state_in = S_WRITE;
         end
         S_WRITE: begin
            ram_wr_en        = 1'b1;
            valid_in[idx_ff] = 1'b1;
            state_in         = S_DONE;
            unique case (mode_ff)
               MODE_CLEAR: begin
                  valid_in         = '0;
                  valid_in[idx_ff] = 1'b1;
                  total_in         = count_ext;
                  last_win_in      = win_ff;
                  last_idx_in      = idx_ff;
               end
               MODE_SAME: begin
                  ram_wr_data = old_count + count_ext;
                  total_in    = total_ff + count_ext;
               end
               MODE_OTHER: begin
                  total_in    = total_ff - old_count + count_ext;
                  last_win_in = win_ff;
                  last_idx_in = idx_ff;
                  ptr_in      = next_slot(last_idx_ff);
                  if (next_slot(last_idx_ff) != idx_ff) begin
                     state_in = S_WALK;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_WALK: begin
            // one skipped slot read per cycle, taken off the total in the next cycle
            ram_rd_en        = 1'b1;
            ram_rd_addr      = ptr_ff;
            sub_pend_in      = valid_ff[ptr_ff];
            valid_in[ptr_ff] = 1'b0;
            ptr_in           = next_slot(ptr_ff);
            if (sub_pend_ff) begin
               total_in = total_ff - ram_rd_data;
            end
            if (next_slot(ptr_ff) == idx_ff) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (sub_pend_ff) begin
               total_in = total_ff - ram_rd_data;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_total_in = total_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         total_ff     <= '0;
         last_win_ff  <= '0;
         last_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         width_ff     <= bswer_pkg::WIDTH_RESET;
         win_ms_ff    <= DW'(bswer_pkg::WIDTH_RESET) * DW'(SLOT_COUNT);
         sub_pend_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         total_ff     <= total_in;
         last_win_ff  <= last_win_in;
         last_idx_ff  <= last_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         width_ff     <= width_in;
         win_ms_ff    <= win_ms_in;
         sub_pend_ff  <= sub_pend_in;
      end
      rsp_total_ff <= rsp_total_in;
      count_ff     <= count_in;
      win_ff       <= win_in;
      idx_ff       <= idx_in;
      mode_ff      <= mode_in;
      cap_valid_ff <= cap_valid_in;
      ptr_ff       <= ptr_in;
   end

`ifndef SYNTHESIS
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIV1 || state_ff == S_DIV2))
      else $error("divider finished outside a divide state");

   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV2 && div_rsp.done) |-> (div_rsp.quotient < TW'(SLOT_COUNT)))
      else $error("slot quotient beyond slot count");

   a_slot_marked: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE) |=> valid_ff[idx_ff])
      else $error("written slot not marked valid");

   a_walk_skips_target: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (ptr_ff != idx_ff))
      else $error("walk reached the current slot");
`endif

endmodule

### tb/bswer_checker.sv
// ----------------------------------------------------------------------------
// bswer_checker
// Watches the req, rsp and csr channels of the sliding window event rate
// block. Keeps its own slot ring and running total, queues the total each
// accepted req word should produce, and compares every accepted rsp word
// with the oldest one queued.
// ----------------------------------------------------------------------------
module bswer_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [bswer_pkg::COUNT_W-1:0]     req_event_count,
   input  logic [bswer_pkg::TIME_W-1:0]      req_time_ms,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [bswer_pkg::TOTAL_W-1:0]     rsp_window_total,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [bswer_pkg::WIDTH_W-1:0]     csr_slot_width_ms,
   output int                                fail_count,
   output int                                pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS  = bswer_pkg::SLOT_COUNT_DEF;
   localparam int SLOT_W = $clog2(SLOTS);

   logic [bswer_pkg::TOTAL_W-1:0] slot_tally [SLOTS];
   logic [bswer_pkg::TOTAL_W-1:0] tally_sum;
   logic [31:0]                   cur_window;
   logic [SLOT_W-1:0]             cur_slot;
   logic [bswer_pkg::WIDTH_W-1:0] slot_ms;
   logic [bswer_pkg::TOTAL_W-1:0] total_q [$];
   logic [bswer_pkg::TOTAL_W-1:0] want_total;
   int                            errors = 0;

   // advance the ring to time t, add cnt, return the new window total
   function automatic logic [31:0] advance_window(input logic [7:0] cnt,
                                                  input logic [31:0] t);
      logic [31:0] w, span, win, idx, i;
      logic        wipe;
      int          k, n;
      w    = (slot_ms == '0) ? 32'd1 : 32'(slot_ms);
      span = w * SLOTS;
      win  = t / span;
      idx  = (t % span) / w;
      if (idx >= SLOTS)
         idx = SLOTS - 1;
      wipe = (win - cur_window) > 32'd1;
      if (win > cur_window && idx >= 32'(cur_slot))
         wipe = 1'b1;
      if (wipe) begin
         for (k = 0; k < SLOTS; k++)
            slot_tally[k] = '0;
         slot_tally[idx] = 32'(cnt);
         tally_sum       = 32'(cnt);
         cur_window      = win;
         cur_slot        = idx[SLOT_W-1:0];
      end else if (idx == 32'(cur_slot)) begin
         slot_tally[idx] = slot_tally[idx] + 32'(cnt);
         tally_sum       = tally_sum + 32'(cnt);
      end else begin
         // walk from the slot after the last one up to the new one, zeroing
         i               = (32'(cur_slot) + 32'd1) % SLOTS;
         tally_sum       = tally_sum - slot_tally[idx];
         slot_tally[idx] = 32'(cnt);
         tally_sum       = tally_sum + 32'(cnt);
         for (n = 0; n < SLOTS && i != idx; n++) begin
            tally_sum     = tally_sum - slot_tally[i];
            slot_tally[i] = '0;
            i             = (i + 32'd1) % SLOTS;
         end
         cur_slot   = idx[SLOT_W-1:0];
         cur_window = win;
      end
      return tally_sum;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SLOTS; k++)
            slot_tally[k] = '0;
         tally_sum  = '0;
         cur_window = '0;
         cur_slot   = '0;
         slot_ms    = bswer_pkg::WIDTH_RESET;
         total_q.delete();
      end else begin
         if (csr_valid && csr_ready)
            slot_ms = csr_slot_width_ms;
         if (rsp_valid && !rsp_stall) begin
            if (total_q.size() == 0) begin
               $error("window_total: no word expected, actual %0d", rsp_window_total);
               errors++;
            end else begin
               want_total = total_q.pop_front();
               if (want_total !== rsp_window_total) begin
                  $error("window_total: expected %0d, actual %0d",
                         want_total, rsp_window_total);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall)
            total_q.push_back(advance_window(req_event_count, req_time_ms));
      end
      fail_count    <= errors;
      pending_count <= total_q.size();
   end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the sliding window event rate block. A directed
// pass walks the slot cases (same slot, skipped slots, earlier slot, window
// roll, long gaps, backward time, zero slot width), then random phases at
// several slot widths drive mostly forward-moving timestamps with random
// gaps and stalls on both sides, the last phase without. Prediction lives in bswer_checker.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASE_ITEMS = 94;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid;
   logic                              req_stall;
   logic [bswer_pkg::COUNT_W-1:0]     req_event_count;
   logic [bswer_pkg::TIME_W-1:0]      req_time_ms;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic [bswer_pkg::TOTAL_W-1:0]     rsp_window_total;
   logic                              csr_valid;
   logic                              csr_ready;
   logic [bswer_pkg::WIDTH_W-1:0]     csr_slot_width_ms;
   int                                fail_count;
   int                                pending_count;

   bit quiet        = 1'b0;   // no idling on either side
   bit hold_off_req = 1'b0;   // ask the receiver for one long hold-off

   bucketed_sliding_window_event_rate u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_event_count  (req_event_count),
      .req_time_ms      (req_time_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_window_total (rsp_window_total),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_slot_width_ms(csr_slot_width_ms)
   );

   bswer_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_event_count  (req_event_count),
      .req_time_ms      (req_time_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_window_total (rsp_window_total),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_slot_width_ms(csr_slot_width_ms),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #6_000_000;
      $display("Regression FAIL");
      $finish;
   end

   task automatic send_word(input logic [7:0] cnt, input logic [31:0] t);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_event_count <= cnt;
      req_time_ms     <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // sender pauses until every queued total has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_width(input logic [15:0] w);
      wait_drained();
      csr_valid         <= 1'b1;
      csr_slot_width_ms <= w;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [7:0] pick_count();
      case ($urandom_range(0, 9))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // mostly forward steps of a slot or so, with window rolls, long gaps,
   // backward jumps and fully random stamps mixed in
   function automatic logic [31:0] next_stamp(input logic [31:0] now,
                                              input logic [15:0] width);
      logic [31:0] w, span;
      int          pick;
      w    = (width == '0) ? 32'd1 : 32'(width);
      span = w * bswer_pkg::SLOT_COUNT_DEF;
      pick = $urandom_range(0, 99);
      if (pick < 15)
         return now + $urandom_range(0, w - 1);
      else if (pick < 55)
         return now + $urandom_range(1, w);
      else if (pick < 75)
         return now + $urandom_range(w, 3 * w);
      else if (pick < 85)
         return now + $urandom_range(span - 2 * w, span + 2 * w);
      else if (pick < 90)
         return now + $urandom_range(2 * span, 5 * span);
      else if (pick < 95)
         return now - $urandom_range(0, 2 * span);
      else
         return $urandom();
   endfunction

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
   end

   initial begin
      logic [15:0] widths [8];
      logic [31:0] stamp;
      int          p, n;

      req_valid         = 1'b0;
      req_event_count   = '0;
      req_time_ms       = '0;
      csr_valid         = 1'b0;
      csr_slot_width_ms = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed, reset slot width of 62 ms: window is 992 ms
      send_word(8'd0,   32'd0);                 // query at reset slot
      send_word(8'd255, 32'd10);                // same slot, add
      send_word(8'd1,   32'd62);                // next slot
      send_word(8'd7,   32'd311);               // skips three slots
      send_word(8'd3,   32'd124);               // earlier slot, walk wraps
      send_word(8'd9,   32'd1054);              // next window, lower slot
      send_word(8'd4,   32'd1178);              // same window forward
      send_word(8'd5,   32'd2170);              // next window, same slot: clear
      send_word(8'd2,   32'd2975);              // last slot
      send_word(8'd6,   32'd2976);              // next window slot 0, wraps
      send_word(8'd0,   32'd8928);              // several windows later
      send_word(8'd8,   32'd3968);              // earlier window: clear
      send_word(8'd255, 32'hFFFF_FFFF);         // largest stamp
      send_word(8'd255, 32'hFFFF_FFFF);
      send_word(8'd0,   32'd0);                 // wrap back to zero

      write_width(16'd1);
      send_word(8'd1, 32'd0);
      send_word(8'd2, 32'd15);
      send_word(8'd3, 32'd16);
      send_word(8'd4, 32'd31);
      send_word(8'd5, 32'd37);

      write_width(16'hFFFF);
      send_word(8'd1,   32'd0);
      send_word(8'd128, 32'hFFFF_FFFF);

      write_width(16'd0);                       // zero width acts as one
      send_word(8'd1, 32'd5);
      send_word(8'd2, 32'd20);

      widths[0] = 16'd62;
      widths[1] = 16'd1;
      widths[2] = 16'hFFFF;
      widths[3] = 16'd0;
      widths[4] = 16'($urandom_range(2, 300));
      widths[5] = 16'($urandom_range(1, 65535));
      widths[6] = 16'($urandom_range(2, 40));
      widths[7] = 16'd62;

      for (p = 0; p < 8; p++) begin
         write_width(widths[p]);
         quiet = (p == 7);
         stamp = ($urandom_range(0, 1) == 0) ? $urandom() : 32'($urandom_range(0, 5000));
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 1 && n == 20)
               hold_off_req = 1'b1;
            if (p == 3 && n == 40)
               wait_drained();
            stamp = next_stamp(stamp, widths[p]);
            send_word(pick_count(), stamp);
         end
      end

      wait_drained();
      if (fail_count == 0 && pending_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### filelist.f
src/bswer_pkg.sv
src/bswer_ram.sv
src/bswer_div.sv
src/bucketed_sliding_window_event_rate.sv
tb/bswer_checker.sv
tb/tb_top.sv
